@@ design/pssm_pkg.sv @@
// shared types and constants for the packet stream statistics monitor
package pssm_pkg;

  localparam int ID_SPACE_DEF = 65536;
  localparam int MAP_W        = 32;
  localparam int DELTA_W      = 40;
  localparam int JIT_W        = 44;
  localparam int PROD_W       = 62;

  localparam logic [29:0]        NS_PER_S  = 30'd1000000000;
  localparam logic [DELTA_W-1:0] DELTA_MAX = '1;
  localparam logic [JIT_W-1:0]   J_MASK    = '1;

  typedef enum logic [0:0] {
    OP_RECORD = 1'b0,
    OP_CLOSE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t          operation;
    logic [31:0]  seq_id;
    logic [31:0]  send_seconds;
    logic [29:0]  send_nanoseconds;
    logic [63:0]  receive_time_ns;
    logic [15:0]  payload_length;
  } in_item_t;

  typedef struct packed {
    logic             is_duplicate;
    logic [63:0]      interval_bytes;
    logic [63:0]      total_bytes;
    logic [31:0]      pkt_rx_count;
    logic [31:0]      out_of_order_count;
    logic [31:0]      duplicate_count;
    logic [JIT_W-1:0] jitter;
    logic [JIT_W-1:0] jitter_min;
    logic [JIT_W-1:0] jitter_max;
    logic [31:0]      expected_packets;
    logic [31:0]      pkt_loss_count;
    logic [63:0]      active_ns;
  } out_item_t;

endpackage

@@ design/pssm_if.sv @@
// valid/ready channels carrying input and result words
interface pssm_in_if import pssm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pssm_out_if import pssm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

@@ design/pssm_ram.sv @@
// generic simple dual port ram with registered read
module pssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/packet_stream_stats_monitor.sv @@
// top level: duplicate filter, jitter, byte and loss statistics for a test packet stream
// throughput: one word per cycle unless a result stalls on out_chan.ready; the seen-id bitmap
//   read-modify-write in stage 1 sets it and forwards the last written row to the next word
// reset: synchronous, clears all statistics, then sweeps the bitmap one 32-bit row per cycle,
//   with in_chan.ready low
module packet_stream_stats_monitor import pssm_pkg::*; #(
  parameter int ID_SPACE = ID_SPACE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  pssm_in_if.sink        in_chan,
  pssm_out_if.source     out_chan
);

  localparam int ROWS   = (ID_SPACE + MAP_W - 1) / MAP_W;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int BIT_AW = $clog2(MAP_W);

  logic adv;
  logic in_fire;

  // config and bitmap clearing
  logic [31:0]       cfg_r;
  logic              clr_active_r;
  logic [ROW_AW-1:0] clr_cnt_r;

  // bitmap ram and forwarding of the last write
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [MAP_W-1:0]  ram_wdata;
  logic [MAP_W-1:0]  ram_rdata;
  logic              fwd_valid_r;
  logic [ROW_AW-1:0] fwd_addr_r;
  logic [MAP_W-1:0]  fwd_data_r;

  // stage 1
  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              first_pending_r;
  logic [ROW_AW-1:0] s1_row;
  logic [BIT_AW-1:0] s1_bit;
  logic              s1_in_map;
  logic              s1_rec;
  logic [MAP_W-1:0]  s1_map;
  logic              s1_dup;
  logic              s1_mark;
  logic              s1_first;
  logic [PROD_W-1:0] s1_prod;

  // stage 2
  logic              s2_valid_r;
  op_t               s2_op_r;
  logic              s2_dup_r;
  logic              s2_first_r;
  logic [31:0]       s2_id_r;
  logic [63:0]       s2_rx_r;
  logic [15:0]       s2_len_r;
  logic [PROD_W-1:0] s2_prod_r;
  logic [29:0]       s2_ns_r;
  logic [63:0]       s2_transit;

  // stage 3
  logic              s3_valid_r;
  op_t               s3_op_r;
  logic              s3_dup_r;
  logic              s3_first_r;
  logic [31:0]       s3_id_r;
  logic [63:0]       s3_rx_r;
  logic [15:0]       s3_len_r;
  logic [63:0]       s3_transit_r;
  logic [63:0]       prev_tr_r;
  logic              s3_upd;
  logic [63:0]       s3_diff;

  // stage 4
  logic               s4_valid_r;
  op_t                s4_op_r;
  logic               s4_dup_r;
  logic               s4_first_r;
  logic [31:0]        s4_id_r;
  logic [63:0]        s4_rx_r;
  logic [15:0]        s4_len_r;
  logic [63:0]        s4_diff_r;
  logic [63:0]        s4_mag;
  logic [DELTA_W-1:0] s4_d;

  // stage 5
  logic               s5_valid_r;
  op_t                s5_op_r;
  logic               s5_dup_r;
  logic               s5_first_r;
  logic [31:0]        s5_id_r;
  logic [63:0]        s5_rx_r;
  logic [15:0]        s5_len_r;
  logic [DELTA_W-1:0] s5_d_r;
  logic               s5_rec;
  logic               s5_upd;
  logic [JIT_W+1:0]   s5_jsum;
  logic [JIT_W-1:0]   s5_jnew;
  logic [63:0]        s5_ibytes;

  // statistics
  logic [JIT_W-1:0] jit_acc_r;
  logic [JIT_W-1:0] jit_low_r;
  logic [JIT_W-1:0] jit_high_r;
  logic [63:0]      first_time_r;
  logic [63:0]      last_time_r;
  logic [31:0]      last_id_r;
  logic [63:0]      byte_total_r;
  logic [63:0]      byte_interval_r;
  logic [31:0]      cnt_rx_r;
  logic [31:0]      cnt_ooo_r;
  logic [31:0]      cnt_dup_r;

  // stage 6 and output
  logic             s6_valid_r;
  logic             s6_dup_r;
  logic             s6_upd_r;
  logic [63:0]      s6_ibytes_r;
  logic [JIT_W-1:0] jit_low_nxt;
  logic [JIT_W-1:0] jit_high_nxt;
  logic [31:0]      expected;
  out_item_t        out_item_nxt;
  out_item_t        out_item_r;
  logic             out_valid_r;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv && !clr_active_r;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      if (clr_cnt_r == ROW_AW'(ROWS - 1)) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + ROW_AW'(1);
      end
    end
  end

  pssm_ram #(
    .WIDTH (MAP_W),
    .DEPTH (ROWS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_chan.item.seq_id[ROW_AW+BIT_AW-1:BIT_AW]),
    .rdata (ram_rdata)
  );

  // stage 1: bitmap test and mark, send time product
  assign s1_row    = s1_item_r.seq_id[ROW_AW+BIT_AW-1:BIT_AW];
  assign s1_bit    = s1_item_r.seq_id[BIT_AW-1:0];
  assign s1_in_map = s1_item_r.seq_id < 32'(ID_SPACE);
  assign s1_rec    = s1_item_r.operation == OP_RECORD;
  // the row written at the edge that issued this read is not in the ram data yet
  assign s1_map    = (fwd_valid_r && fwd_addr_r == s1_row) ? fwd_data_r : ram_rdata;
  assign s1_dup    = s1_rec && s1_in_map && s1_map[s1_bit];
  assign s1_mark   = s1_valid_r && s1_rec && s1_in_map && adv;
  assign s1_first  = s1_rec && first_pending_r;
  assign s1_prod   = PROD_W'(s1_item_r.send_seconds) * PROD_W'(NS_PER_S);

  assign ram_we    = clr_active_r || s1_mark;
  assign ram_waddr = clr_active_r ? clr_cnt_r : s1_row;
  assign ram_wdata = clr_active_r ? '0 : (s1_map | (MAP_W'(1) << s1_bit));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (ram_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr_r <= ram_waddr;
      fwd_data_r <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pending_r <= 1'b1;
    end else if (adv && s1_valid_r && s1_rec) begin
      first_pending_r <= 1'b0;
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_fire;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      s6_valid_r  <= s5_valid_r;
      out_valid_r <= s6_valid_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= in_chan.item;

      s2_op_r    <= s1_item_r.operation;
      s2_dup_r   <= s1_dup;
      s2_first_r <= s1_first;
      s2_id_r    <= s1_item_r.seq_id;
      s2_rx_r    <= s1_item_r.receive_time_ns;
      s2_len_r   <= s1_item_r.payload_length;
      s2_prod_r  <= s1_prod;
      s2_ns_r    <= s1_item_r.send_nanoseconds;

      s3_op_r      <= s2_op_r;
      s3_dup_r     <= s2_dup_r;
      s3_first_r   <= s2_first_r;
      s3_id_r      <= s2_id_r;
      s3_rx_r      <= s2_rx_r;
      s3_len_r     <= s2_len_r;
      s3_transit_r <= s2_transit;

      s4_op_r    <= s3_op_r;
      s4_dup_r   <= s3_dup_r;
      s4_first_r <= s3_first_r;
      s4_id_r    <= s3_id_r;
      s4_rx_r    <= s3_rx_r;
      s4_len_r   <= s3_len_r;
      s4_diff_r  <= s3_diff;

      s5_op_r    <= s4_op_r;
      s5_dup_r   <= s4_dup_r;
      s5_first_r <= s4_first_r;
      s5_id_r    <= s4_id_r;
      s5_rx_r    <= s4_rx_r;
      s5_len_r   <= s4_len_r;
      s5_d_r     <= s4_d;

      s6_dup_r    <= s5_rec && s5_dup_r;
      s6_upd_r    <= s5_upd;
      s6_ibytes_r <= s5_ibytes;

      out_item_r <= out_item_nxt;
    end
  end

  // stage 2: transit time, receive minus send, two's complement
  assign s2_transit = s2_rx_r - 64'(s2_prod_r) - 64'(s2_ns_r);

  // stage 3: change in transit against the last accepted packet
  assign s3_upd  = s3_valid_r && s3_op_r == OP_RECORD && !s3_dup_r;
  assign s3_diff = s3_first_r ? '0 : (s3_transit_r - prev_tr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_tr_r <= '0;
    end else if (adv && s3_upd) begin
      prev_tr_r <= s3_transit_r;
    end
  end

  // stage 4: magnitude, saturated to 40 bits
  assign s4_mag = s4_diff_r[63] ? (64'd0 - s4_diff_r) : s4_diff_r;
  assign s4_d   = (|s4_mag[63:DELTA_W]) ? DELTA_MAX : s4_mag[DELTA_W-1:0];

  // stage 5: jitter update and counters
  assign s5_rec = s5_op_r == OP_RECORD;
  assign s5_upd = s5_valid_r && s5_rec && !s5_dup_r;
  // (j + 8) >> 4 equals (j >> 4) plus bit 3 of j
  assign s5_jsum = {2'b00, jit_acc_r} + (JIT_W+2)'(s5_d_r)
                 - (JIT_W+2)'(jit_acc_r >> 4) - (JIT_W+2)'(jit_acc_r[3]);
  assign s5_jnew = (s5_jsum > (JIT_W+2)'(J_MASK)) ? J_MASK : s5_jsum[JIT_W-1:0];
  assign s5_ibytes = s5_upd ? (byte_interval_r + 64'(s5_len_r)) : byte_interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jit_acc_r       <= '0;
      first_time_r    <= '0;
      last_time_r     <= '0;
      last_id_r       <= '0;
      byte_total_r    <= '0;
      byte_interval_r <= '0;
      cnt_rx_r        <= '0;
      cnt_ooo_r       <= '0;
      cnt_dup_r       <= '0;
    end else if (adv && s5_valid_r) begin
      if (s5_rec) begin
        if (s5_dup_r) begin
          cnt_dup_r <= cnt_dup_r + 32'd1;
        end else begin
          if (s5_first_r) begin
            first_time_r <= s5_rx_r;
          end else if (s5_id_r < last_id_r) begin
            cnt_ooo_r <= cnt_ooo_r + 32'd1;
          end
          last_id_r       <= s5_id_r;
          last_time_r     <= s5_rx_r;
          jit_acc_r       <= s5_jnew;
          byte_total_r    <= byte_total_r + 64'(s5_len_r);
          byte_interval_r <= s5_ibytes;
          cnt_rx_r        <= cnt_rx_r + 32'd1;
        end
      end else begin
        byte_interval_r <= '0;
      end
    end
  end

  // stage 6: running min and max, snapshot
  assign jit_low_nxt  = (s6_upd_r && jit_acc_r < jit_low_r) ? jit_acc_r : jit_low_r;
  assign jit_high_nxt = (s6_upd_r && jit_acc_r > jit_high_r) ? jit_acc_r : jit_high_r;
  assign expected     = (cfg_r != 32'd0) ? cfg_r : last_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jit_low_r  <= J_MASK;
      jit_high_r <= '0;
    end else if (adv && s6_valid_r) begin
      jit_low_r  <= jit_low_nxt;
      jit_high_r <= jit_high_nxt;
    end
  end

  always_comb begin
    out_item_nxt.is_duplicate       = s6_dup_r;
    out_item_nxt.interval_bytes     = s6_ibytes_r;
    out_item_nxt.total_bytes        = byte_total_r;
    out_item_nxt.pkt_rx_count       = cnt_rx_r;
    out_item_nxt.out_of_order_count = cnt_ooo_r;
    out_item_nxt.duplicate_count    = cnt_dup_r;
    out_item_nxt.jitter             = jit_acc_r;
    // all ones means no value yet
    out_item_nxt.jitter_min         = (jit_low_nxt == J_MASK) ? '0 : jit_low_nxt;
    out_item_nxt.jitter_max         = jit_high_nxt;
    out_item_nxt.expected_packets   = expected;
    out_item_nxt.pkt_loss_count     = (expected > cnt_rx_r) ? (expected - cnt_rx_r) : 32'd0;
    out_item_nxt.active_ns          = last_time_r - first_time_r;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.item  = out_item_r;

  // no word may be in stage 1 or 2 while the bitmap sweep runs
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!s1_valid_r && !s2_valid_r))
    else $error("word in pipeline during bitmap clear");

  a_jit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (jit_low_r != J_MASK) |-> (jit_low_r <= jit_high_r))
    else $error("jitter min above jitter max");

  a_rx_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s5_upd) |=> (cnt_rx_r == $past(cnt_rx_r) + 32'd1))
    else $error("received count not advanced by accepted packet");

endmodule

@@ tb/sv/tb_packet_stream_stats_monitor.sv @@
// self-checking testbench for the packet stream statistics monitor
module tb_packet_stream_stats_monitor import pssm_pkg::*; ();

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  pssm_in_if  in_chan();
  pssm_out_if out_chan();

  packet_stream_stats_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // predictor state
  bit          seen_ids [ID_SPACE_DEF];
  bit          first_pending = 1'b1;
  logic [63:0] first_rx      = '0;
  logic [63:0] last_rx       = '0;
  logic [31:0] last_id       = '0;
  logic [63:0] prev_transit  = '0;
  logic [63:0] jit_acc       = '0;
  logic [63:0] jit_low       = 64'(J_MASK);
  logic [63:0] jit_high      = '0;
  logic [63:0] bytes_total   = '0;
  logic [63:0] bytes_interval = '0;
  logic [31:0] cnt_rx        = '0;
  logic [31:0] cnt_ooo       = '0;
  logic [31:0] cnt_dup       = '0;
  logic [31:0] sender_count  = '0;

  out_item_t snapshots_due[$];
  int        mismatches = 0;
  int        send_pct   = 0;
  int        stall_pct  = 0;
  int        hold_reqs  = 0;
  int        hold_taken = 0;
  int        hold_left  = 0;

  // synthetic sender
  logic [31:0] next_seq;
  logic [63:0] net_clock;
  logic [63:0] path_delay;

  out_item_t want_word;
  out_item_t got_word;

  function automatic out_item_t stats_after_word(in_item_t w);
    logic [63:0] sent;
    logic [63:0] transit;
    logic [63:0] d;
    logic [63:0] j;
    logic [31:0] want_pkts;
    out_item_t   r;
    r = '0;
    if (w.operation == OP_RECORD) begin
      sent = 64'(w.send_seconds) * 64'd1_000_000_000 + 64'(w.send_nanoseconds);
      transit = w.receive_time_ns - sent;
      if (first_pending) begin
        first_rx = w.receive_time_ns;
        last_id = w.seq_id;
        prev_transit = transit;
        first_pending = 1'b0;
      end
      if (w.seq_id < ID_SPACE_DEF && seen_ids[w.seq_id]) begin
        cnt_dup++;
        r.is_duplicate = 1'b1;
      end else begin
        if (w.seq_id < ID_SPACE_DEF) seen_ids[w.seq_id] = 1'b1;
        if (w.seq_id < last_id) cnt_ooo++;
        last_id = w.seq_id;
        d = transit - prev_transit;
        if (d[63]) d = -d;
        if (d > 64'(DELTA_MAX)) d = 64'(DELTA_MAX);
        j = jit_acc + d - ((jit_acc + 64'd8) >> 4);
        if (j > 64'(J_MASK)) j = 64'(J_MASK);
        jit_acc = j;
        if (j < jit_low) jit_low = j;
        if (j > jit_high) jit_high = j;
        prev_transit = transit;
        bytes_total += 64'(w.payload_length);
        bytes_interval += 64'(w.payload_length);
        cnt_rx++;
        last_rx = w.receive_time_ns;
      end
    end
    want_pkts = (sender_count != 0) ? sender_count : last_id;
    r.interval_bytes     = bytes_interval;
    r.total_bytes        = bytes_total;
    r.pkt_rx_count       = cnt_rx;
    r.out_of_order_count = cnt_ooo;
    r.duplicate_count    = cnt_dup;
    r.jitter             = jit_acc[JIT_W-1:0];
    r.jitter_min         = (jit_low == 64'(J_MASK)) ? '0 : jit_low[JIT_W-1:0];
    r.jitter_max         = jit_high[JIT_W-1:0];
    r.expected_packets   = want_pkts;
    r.pkt_loss_count     = (want_pkts > cnt_rx) ? want_pkts - cnt_rx : '0;
    r.active_ns          = last_rx - first_rx;
    if (w.operation == OP_CLOSE) bytes_interval = '0;
    return r;
  endfunction

  function automatic in_item_t pkt(logic [31:0] id, logic [31:0] sec, logic [29:0] ns,
                                   logic [63:0] rx, logic [15:0] len);
    in_item_t w;
    w.operation        = OP_RECORD;
    w.seq_id           = id;
    w.send_seconds     = sec;
    w.send_nanoseconds = ns;
    w.receive_time_ns  = rx;
    w.payload_length   = len;
    return w;
  endfunction

  // close word with junk packet fields, which must be ignored
  function automatic in_item_t close_word();
    in_item_t w;
    w = pkt($urandom, $urandom, 30'($urandom_range(0, 999999999)),
            {$urandom, $urandom}, 16'($urandom));
    w.operation = OP_CLOSE;
    return w;
  endfunction

  function automatic in_item_t traffic_word();
    int          pick;
    logic [31:0] id;
    logic [63:0] rx;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 5) return close_word();
    if (pick < 12) return pkt($urandom, $urandom, 30'($urandom_range(0, 999999999)),
                              {$urandom, $urandom}, 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      id = next_seq;
      next_seq++;
    end else if (pick < 90) begin
      // late arrival or repeat of a recent id
      id = next_seq - 32'($urandom_range(1, 8));
    end else if (pick < 96) begin
      next_seq += 32'($urandom_range(1, 4));
      id = next_seq;
      next_seq++;
    end else begin
      id = $urandom | 32'h0001_0000;
    end
    net_clock += 64'($urandom_range(1000, 3_000_000));
    rx = net_clock + path_delay + 64'($urandom_range(0, 400_000));
    if ($urandom_range(0, 49) == 0) rx += 64'($urandom) << 8;
    len = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(40, 1500)) : 16'($urandom);
    return pkt(id, 32'(net_clock / 64'd1_000_000_000),
               30'(net_clock % 64'd1_000_000_000), rx, len);
  endfunction

  // offers one word from a falling edge, returns at the rising edge that takes it
  task automatic send_word(in_item_t w, bit typed, out_item_t want);
    out_item_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.item  <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pred = stats_after_word(w);
    snapshots_due.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (snapshots_due.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic write_sender_count(logic [31:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sender_count = v;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #600000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_taken) begin
        hold_taken = hold_reqs;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready) begin
      got_word = out_chan.item;
      if (snapshots_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none got %p", $time, got_word);
        mismatches++;
      end else begin
        want_word = snapshots_due.pop_front();
        check_field("is_duplicate", 64'(want_word.is_duplicate), 64'(got_word.is_duplicate));
        check_field("interval_bytes", want_word.interval_bytes, got_word.interval_bytes);
        check_field("total_bytes", want_word.total_bytes, got_word.total_bytes);
        check_field("pkt_rx_count", 64'(want_word.pkt_rx_count),
                    64'(got_word.pkt_rx_count));
        check_field("out_of_order_count", 64'(want_word.out_of_order_count),
                    64'(got_word.out_of_order_count));
        check_field("duplicate_count", 64'(want_word.duplicate_count),
                    64'(got_word.duplicate_count));
        check_field("jitter", 64'(want_word.jitter), 64'(got_word.jitter));
        check_field("jitter_min", 64'(want_word.jitter_min), 64'(got_word.jitter_min));
        check_field("jitter_max", 64'(want_word.jitter_max), 64'(got_word.jitter_max));
        check_field("expected_packets", 64'(want_word.expected_packets),
                    64'(got_word.expected_packets));
        check_field("pkt_loss_count", 64'(want_word.pkt_loss_count),
                    64'(got_word.pkt_loss_count));
        check_field("active_ns", want_word.active_ns, got_word.active_ns);
      end
    end
  end

  initial begin
    stim_row_t   directed[$];
    logic [31:0] phase_cfg [5];
    int          send_pcts [5] = '{0, 81, 0, 18, 0};
    int          stall_pcts[5] = '{0, 0, 81, 18, 0};

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_chan.valid = 1'b0;
    in_chan.item  = '0;
    next_seq      = 32'($urandom_range(300, 2000));
    net_clock     = 64'($urandom_range(0, 4000)) * 64'd1_000_000_000;
    phase_cfg     = '{32'hFFFF_FFFF, 32'd1, 32'd0, $urandom, 32'($urandom_range(1, 3000))};

    // nothing recorded yet: all zero
    directed.push_back('{close_word(), 1'b1, out_item_t'('0)});
    // first packet sets the baseline, so no jitter
    directed.push_back('{pkt(32'd5, 32'd0, 30'd0, 64'd1000, 16'd100), 1'b1,
      out_item_t'{is_duplicate: 1'b0, interval_bytes: 64'd100, total_bytes: 64'd100,
                  pkt_rx_count: 32'd1, out_of_order_count: 32'd0, duplicate_count: 32'd0,
                  jitter: '0, jitter_min: '0, jitter_max: '0, expected_packets: 32'd5,
                  pkt_loss_count: 32'd4, active_ns: 64'd0}});
    // duplicate only bumps its count
    directed.push_back('{pkt(32'd5, 32'd7, 30'd7, 64'd99, 16'd1), 1'b1,
      out_item_t'{is_duplicate: 1'b1, interval_bytes: 64'd100, total_bytes: 64'd100,
                  pkt_rx_count: 32'd1, out_of_order_count: 32'd0, duplicate_count: 32'd1,
                  jitter: '0, jitter_min: '0, jitter_max: '0, expected_packets: 32'd5,
                  pkt_loss_count: 32'd4, active_ns: 64'd0}});
    directed.push_back('{pkt(32'd0, 32'd0, 30'd0, 64'd17000, 16'd0), 1'b0, '0});
    directed.push_back('{pkt(32'd65535, 32'd0, 30'd999999999, 64'd1_000_020_000, 16'hFFFF),
                         1'b0, '0});
    directed.push_back('{pkt(32'd65536, 32'd1, 30'd0, 64'd1_000_030_000, 16'd64), 1'b0, '0});
    directed.push_back('{pkt(32'd65536, 32'd1, 30'd10, 64'd1_000_030_500, 16'd64), 1'b0, '0});
    directed.push_back('{pkt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'd999999999, '1, 16'hFFFF),
                         1'b0, '0});
    directed.push_back('{pkt(32'hFFFF_FFFF, 32'd0, 30'd0, 64'd0, 16'd0), 1'b0, '0});
    directed.push_back('{close_word(), 1'b0, '0});
    directed.push_back('{close_word(), 1'b0, '0});
    directed.push_back('{pkt(32'd100, 32'd0, 30'd0, 64'h8000_0000_0000_0000, 16'd7), 1'b0, '0});
    directed.push_back('{pkt(32'd101, 32'd10, 30'd500, 64'd10_000_000_700, 16'd9), 1'b0, '0});
    directed.push_back('{pkt(32'd99, 32'd10, 30'd900, 64'd10_000_001_000, 16'd3), 1'b0, '0});
    directed.push_back('{pkt(32'd0, 32'd11, 30'd0, 64'd11_000_000_000, 16'd5), 1'b0, '0});
    directed.push_back('{pkt(32'd65535, 32'd11, 30'd0, 64'd11_000_000_000, 16'd5), 1'b0, '0});
    // steady transit: jitter decays
    for (int k = 0; k < 4; k++) begin
      directed.push_back('{pkt(32'(200 + k), 32'd12, 30'(k * 1000), 64'd12_000_005_000 +
                               64'(k * 1000), 16'd1), 1'b0, '0});
    end
    directed.push_back('{close_word(), 1'b0, '0});

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_sender_count(32'd0);

    foreach (directed[r]) send_word(directed[r].word, directed[r].typed, directed[r].want);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_sender_count(phase_cfg[p]);
      send_pct   = send_pcts[p];
      stall_pct  = stall_pcts[p];
      path_delay = 64'($urandom_range(10_000, 50_000_000));
      if ($urandom_range(0, 1) != 0) path_delay = -path_delay;
      for (int n = 0; n < 190; n++) begin
        if (p == 3 && n == 40) hold_reqs++;
        if (p == 2 && n == 95) wait_drained();
        send_word(traffic_word(), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (12) @(posedge clk);
    if (mismatches == 0 && snapshots_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (snapshots_due.size() != 0)
        $display("%0t: %0d result words expected but never seen", $time, snapshots_due.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
